/* hw/rtl/dffp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and digit helper for the decimal field frame parser.
package dffp_pkg;

    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_NINE        = 8'h39;
    localparam logic [6:0] FIELD_MAX        = 7'd99;
    localparam int         DIGIT_BASE       = 10;
    localparam logic [7:0] START_CHAR_RESET = 8'd35;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_SND  = 3'd2,
        PH_LEN  = 3'd3,
        PH_PAY  = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] command;
        logic [6:0] sender;
        logic [6:0] payload_len;
        logic [7:0] payload_byte;
        logic [6:0] byte_index;
    } result_t;

    // acc * 10 + d, saturating at 99
    function automatic logic [6:0] add_digit(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] sum;
        begin
            sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {7'd0, d};
            if (sum > 11'(FIELD_MAX))
            begin
                add_digit = FIELD_MAX;
            end
            else
            begin
                add_digit = sum[6:0];
            end
        end
    endfunction

endpackage

/* hw/rtl/decimal_field_frame_parser.sv */
`timescale 1ns / 1ps
// Start-delimited ASCII decimal frame parser, top level.
// A byte's result is registered into the output register, or the skid entry if the output is held.
// Throughput: one byte per cycle while the skid is empty; the parse step is a single pass of logic
// on the frame state registers, and a one-entry skid stage keeps input flowing while a result waits.
// Reset (rst_n, async low): hunting for start, fields cleared, start_char = '#', outputs empty.
module decimal_field_frame_parser #(
    parameter int COMMAND_DIGITS = 2,
    parameter int SENDER_DIGITS  = 2,
    parameter int LENGTH_DIGITS  = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: start character
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // byte input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       flush,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [6:0] command,
    output logic [6:0] sender,
    output logic [6:0] payload_len,
    output logic [7:0] payload_byte,
    output logic [6:0] byte_index
);
    import dffp_pkg::*;

    // digit counter sized for the widest field
    localparam int MAX_DIGITS_CS = (COMMAND_DIGITS > SENDER_DIGITS) ? COMMAND_DIGITS
                                                                     : SENDER_DIGITS;
    localparam int MAX_DIGITS    = (MAX_DIGITS_CS > LENGTH_DIGITS) ? MAX_DIGITS_CS
                                                                     : LENGTH_DIGITS;
    localparam int DIGIT_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [DIGIT_W:0] CMD_NEED = (DIGIT_W + 1)'(COMMAND_DIGITS);
    localparam logic [DIGIT_W:0] SND_NEED = (DIGIT_W + 1)'(SENDER_DIGITS);
    localparam logic [DIGIT_W:0] LEN_NEED = (DIGIT_W + 1)'(LENGTH_DIGITS);

    logic [7:0]         start_char_reg;
    phase_t             phase_reg, phase_next;
    logic [DIGIT_W-1:0] digit_count_reg, digit_count_next;
    logic [6:0]         command_acc_reg, command_acc_next;
    logic [6:0]         sender_acc_reg, sender_acc_next;
    logic [6:0]         length_acc_reg, length_acc_next;
    logic [6:0]         payload_count_reg, payload_count_next;

    // output register plus skid entry
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic    in_xfer;
    logic    res_valid;
    result_t res_data;

    // phase as seen after an optional flush
    phase_t     cur_phase;
    logic       is_digit;
    logic [3:0] digit;
    logic [DIGIT_W:0] count_inc;
    logic [7:0] pay_inc;
    logic       hunt_hit;

    assign in_ready = !skid_valid_reg;
    assign in_xfer  = in_valid && in_ready;

    assign cur_phase = flush ? PH_HUNT : phase_reg;
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit     = rx_byte[3:0];
    assign count_inc = {1'b0, digit_count_reg} + {{DIGIT_W{1'b0}}, 1'b1};
    assign pay_inc   = {1'b0, payload_count_reg} + 8'd1;
    assign hunt_hit  = (rx_byte == start_char_reg);

    // next frame state
    always_comb
    begin
        phase_next         = phase_reg;
        digit_count_next   = digit_count_reg;
        command_acc_next   = command_acc_reg;
        sender_acc_next    = sender_acc_reg;
        length_acc_next    = length_acc_reg;
        payload_count_next = payload_count_reg;
        if (flush)
        begin
            digit_count_next   = '0;
            command_acc_next   = '0;
            sender_acc_next    = '0;
            length_acc_next    = '0;
            payload_count_next = '0;
        end
        unique case (cur_phase)
            PH_CMD, PH_SND, PH_LEN:
            begin
                if (!is_digit)
                begin
                    // reject, then treat the byte as a hunting byte
                    digit_count_next   = '0;
                    command_acc_next   = '0;
                    sender_acc_next    = '0;
                    length_acc_next    = '0;
                    payload_count_next = '0;
                    phase_next         = hunt_hit ? PH_CMD : PH_HUNT;
                end
                else
                begin
                    digit_count_next = count_inc[DIGIT_W-1:0];
                    unique case (cur_phase)
                        PH_CMD:
                        begin
                            command_acc_next = add_digit(command_acc_reg, digit);
                            if (count_inc >= CMD_NEED)
                            begin
                                digit_count_next = '0;
                                phase_next       = PH_SND;
                            end
                        end
                        PH_SND:
                        begin
                            sender_acc_next = add_digit(sender_acc_reg, digit);
                            if (count_inc >= SND_NEED)
                            begin
                                digit_count_next = '0;
                                phase_next       = PH_LEN;
                            end
                        end
                        default:
                        begin
                            length_acc_next = add_digit(length_acc_reg, digit);
                            if (count_inc >= LEN_NEED)
                            begin
                                digit_count_next   = '0;
                                payload_count_next = '0;
                                phase_next = (length_acc_next == 7'd0) ? PH_END : PH_PAY;
                            end
                        end
                    endcase
                end
            end
            PH_PAY:
            begin
                payload_count_next = pay_inc[6:0];
                if (pay_inc >= {1'b0, length_acc_reg})
                begin
                    phase_next = PH_END;
                end
            end
            default:
            begin
                // hunting, or the accepting byte (also a hunting byte)
                digit_count_next   = '0;
                command_acc_next   = '0;
                sender_acc_next    = '0;
                length_acc_next    = '0;
                payload_count_next = '0;
                phase_next         = hunt_hit ? PH_CMD : PH_HUNT;
            end
        endcase
    end

    // result of this byte
    always_comb
    begin
        res_valid             = 1'b0;
        res_data.kind         = KIND_PAYLOAD;
        res_data.command      = command_acc_reg;
        res_data.sender       = sender_acc_reg;
        res_data.payload_len  = length_acc_reg;
        res_data.payload_byte = 8'd0;
        res_data.byte_index   = 7'd0;
        unique case (cur_phase)
            PH_CMD, PH_SND, PH_LEN:
            begin
                if (!is_digit)
                begin
                    res_valid     = 1'b1;
                    res_data.kind = KIND_REJECT;
                end
            end
            PH_PAY:
            begin
                res_valid             = 1'b1;
                res_data.payload_byte = rx_byte;
                res_data.byte_index   = payload_count_reg;
            end
            PH_END:
            begin
                res_valid     = 1'b1;
                res_data.kind = KIND_ACCEPT;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // output register / skid steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = in_xfer && res_valid;
                skid_data_next  = res_data;
            end
            else
            begin
                out_valid_next = in_xfer && res_valid;
                out_data_next  = res_data;
            end
        end
        else if (in_xfer && res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg    <= START_CHAR_RESET;
            phase_reg         <= PH_HUNT;
            digit_count_reg   <= '0;
            command_acc_reg   <= '0;
            sender_acc_reg    <= '0;
            length_acc_reg    <= '0;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_char_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                phase_reg         <= phase_next;
                digit_count_reg   <= digit_count_next;
                command_acc_reg   <= command_acc_next;
                sender_acc_reg    <= sender_acc_next;
                length_acc_reg    <= length_acc_next;
                payload_count_reg <= payload_count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_data_reg.kind;
    assign command      = out_data_reg.command;
    assign sender       = out_data_reg.sender;
    assign payload_len  = out_data_reg.payload_len;
    assign payload_byte = out_data_reg.payload_byte;
    assign byte_index   = out_data_reg.byte_index;

endmodule

/* dv/decimal_field_frame_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the frame parser: directed frames, then random traffic, partly under back-pressure.
module decimal_field_frame_parser_test;
    import dffp_pkg::*;

    localparam int CMD_DIGITS   = 2;
    localparam int SND_DIGITS   = 2;
    localparam int LEN_DIGITS   = 2;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 4;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'd0;
    logic       flush       = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] kind;
    logic [6:0] command;
    logic [6:0] sender;
    logic [6:0] payload_len;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;

    decimal_field_frame_parser #(
        .COMMAND_DIGITS(CMD_DIGITS),
        .SENDER_DIGITS (SND_DIGITS),
        .LENGTH_DIGITS (LEN_DIGITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .flush       (flush),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .command     (command),
        .sender      (sender),
        .payload_len (payload_len),
        .payload_byte(payload_byte),
        .byte_index  (byte_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int flush_pct      = 0;
    int items_sent     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // generator view of the link
    logic [7:0] start_now  = START_CHAR_RESET;
    bit         frame_open = 1'b0;

    // parser shadow state
    logic [7:0] pr_start  = START_CHAR_RESET;
    phase_t     pr_phase  = PH_HUNT;
    int         pr_digits = 0;
    logic [6:0] pr_cmd    = 7'd0;
    logic [6:0] pr_snd    = 7'd0;
    logic [6:0] pr_len    = 7'd0;
    logic [6:0] pr_count  = 7'd0;

    result_t frame_events_due[$];

    function automatic void clear_frame_state();
        pr_phase  = PH_HUNT;
        pr_digits = 0;
        pr_cmd    = 7'd0;
        pr_snd    = 7'd0;
        pr_len    = 7'd0;
        pr_count  = 7'd0;
    endfunction

    function automatic void hunt(input logic [7:0] b);
        clear_frame_state();
        if (b == pr_start)
        begin
            pr_phase = PH_CMD;
        end
    endfunction

    function automatic logic [6:0] accumulate(input logic [6:0] acc, input int d);
        int v;
        v = int'(acc) * DIGIT_BASE + d;
        return (v > int'(FIELD_MAX)) ? FIELD_MAX : 7'(v);
    endfunction

    function automatic result_t make_event(input kind_t k, input logic [7:0] pb,
                                           input logic [6:0] idx);
        result_t r;
        r.kind         = k;
        r.command      = pr_cmd;
        r.sender       = pr_snd;
        r.payload_len  = pr_len;
        r.payload_byte = pb;
        r.byte_index   = idx;
        return r;
    endfunction

    // one accepted byte through the shadow parser
    function automatic void parse_rx_byte(input logic [7:0] b, input logic fl);
        int need;
        int d;
        need = 0;
        d    = int'(b) - int'(CHAR_ZERO);
        if (fl)
        begin
            clear_frame_state();
        end
        case (pr_phase)
            PH_CMD, PH_SND, PH_LEN:
            begin
                if (b < CHAR_ZERO || b > CHAR_NINE)
                begin
                    frame_events_due.push_back(make_event(KIND_REJECT, 8'd0, 7'd0));
                    hunt(b);
                end
                else
                begin
                    case (pr_phase)
                        PH_CMD:
                        begin
                            pr_cmd = accumulate(pr_cmd, d);
                            need   = CMD_DIGITS;
                        end
                        PH_SND:
                        begin
                            pr_snd = accumulate(pr_snd, d);
                            need   = SND_DIGITS;
                        end
                        default:
                        begin
                            pr_len = accumulate(pr_len, d);
                            need   = LEN_DIGITS;
                        end
                    endcase
                    pr_digits++;
                    if (pr_digits >= need)
                    begin
                        pr_digits = 0;
                        case (pr_phase)
                            PH_CMD:  pr_phase = PH_SND;
                            PH_SND:  pr_phase = PH_LEN;
                            default:
                            begin
                                pr_count = 7'd0;
                                pr_phase = (pr_len == 7'd0) ? PH_END : PH_PAY;
                            end
                        endcase
                    end
                end
            end
            PH_PAY:
            begin
                frame_events_due.push_back(make_event(KIND_PAYLOAD, b, pr_count));
                pr_count++;
                if (pr_count >= pr_len)
                begin
                    pr_phase = PH_END;
                end
            end
            PH_END:
            begin
                frame_events_due.push_back(make_event(KIND_ACCEPT, 8'd0, 7'd0));
                hunt(b);
            end
            default:
            begin
                hunt(b);
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_result();
        result_t due;
        if (frame_events_due.size() == 0)
        begin
            $error("unexpected result transfer: kind %0d", kind);
            mismatches++;
        end
        else
        begin
            due = frame_events_due.pop_front();
            check_field("kind",         8'(due.kind),         8'(kind));
            check_field("command",      8'(due.command),      8'(command));
            check_field("sender",       8'(due.sender),       8'(sender));
            check_field("payload_len",  8'(due.payload_len),  8'(payload_len));
            check_field("payload_byte", due.payload_byte,     payload_byte);
            check_field("byte_index",   8'(due.byte_index),   8'(byte_index));
        end
    endtask

    // monitor: results first, since a result never comes from the byte of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (cfg_wr_en)
            begin
                pr_start = cfg_wr_data;
            end
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte, flush);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("decimal_field_frame_parser_test: errors");
                    $finish;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic bit pick_flush();
        return $urandom_range(99) < flush_pct;
    endfunction

    // one byte transfer; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic fl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        flush    <= fl;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
        end
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
        flush    <= 1'b0;
    endtask

    task automatic quiesce();
        release_input();
        while (frame_events_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_start_char(input logic [7:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        start_now    = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            b = b ^ 8'h40;
        end
        return b;
    endfunction

    // bad_pos < 0: well-formed; else index of the digit replaced by a non-digit
    task automatic send_frame(input int cmd, input int snd, input int len, input int bad_pos,
                              input bit trailer_is_start);
        int         fields[3];
        int         pos;
        int         digit;
        logic [7:0] b;
        fields = '{cmd, snd, len};
        pos    = 0;
        if (!frame_open)
        begin
            send_byte(start_now, pick_flush());
        end
        frame_open = 1'b0;
        for (int f = 0; f < 3; f++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                digit = (d == 0) ? fields[f] / 10 : fields[f] % 10;
                b     = CHAR_ZERO + 8'(digit);
                if (pos == bad_pos)
                begin
                    b = non_digit();
                    send_byte(b, pick_flush());
                    frame_open = (b == start_now);
                    return;
                end
                send_byte(b, pick_flush());
                pos++;
            end
        end
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(255)), pick_flush());
        end
        b = trailer_is_start ? start_now : 8'($urandom_range(255));
        send_byte(b, pick_flush());
        frame_open = (b == start_now);
    endtask

    task automatic test_empty_payload();
        send_text("#009900");
        send_byte(8'hFF, 1'b0);
    endtask

    // accepting byte equal to the start char opens the next frame at once
    task automatic test_payload_extremes();
        send_text("#990002");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("#");
    endtask

    // partial command, bytes just outside the digit range, flush that lands on a start char
    task automatic test_reject_and_flush();
        send_text("1/");
        send_byte("#", 1'b1);
        send_text(":");
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [7:0] start, input int n_items);
        int stop_at;
        int len;
        int bad;
        quiesce();
        write_start_char(start);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        flush_pct      = 2;
        frame_open     = 1'b0;
        stop_at        = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), pick_flush());
                frame_open = 1'b0;
            end
            else
            begin
                if ($urandom_range(99) < 3)
                begin
                    len = 99;
                end
                else if ($urandom_range(99) < 15)
                begin
                    len = 0;
                end
                else
                begin
                    len = $urandom_range(1, 8);
                end
                bad = ($urandom_range(99) < 15) ? $urandom_range(5) : -1;
                send_frame($urandom_range(99), $urandom_range(99), len, bad,
                           $urandom_range(99) < 20);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_payload();
        test_payload_extremes();
        test_reject_and_flush();

        test_random_traffic(25, 76, 8'h00, 300);
        test_random_traffic(76, 25, 8'hFF, 300);
        test_random_traffic(0, 0, "5", 300);
        test_random_traffic(0, 0, START_CHAR_RESET, 350);

        quiesce();
        if (mismatches == 0)
        begin
            $display("decimal_field_frame_parser_test: clean");
        end
        else
        begin
            $display("decimal_field_frame_parser_test: errors");
        end
        $finish;
    end

endmodule
